### rtl/core/pffrs_pkg.sv
// Package for the paged first-fit record store: item types and codes.
// Used by the top level and the assertion checker.
`timescale 1ns / 1ps
package pffrs_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [16:0] HeaderBytes  = 17'd16;
  localparam logic [16:0] SlotOverhead = 17'd4;
  localparam logic [15:0] PageSizeRst  = 16'd4096;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        record_size;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] page_index;
    logic [5:0] slot_index;
    logic [4:0] page_count;
    logic [6:0] record_count;
    logic       last;
  } out_item_t;

endpackage

### rtl/core/pffrs_page_table.sv
// Per-page table: free bytes and record count in one synchronous memory.
// Depends on nothing but its parameters; the read is registered.
`timescale 1ns / 1ps
module pffrs_page_table #(
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [16:0]   wfree_i,
  input  logic [10:0]   wcnt_i,
  input  logic [AW-1:0] raddr_i,
  output logic [16:0]   rfree_o,
  output logic [10:0]   rcnt_o
);
  logic [27:0] mem [2**AW];
  logic [27:0] rd_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wfree_i, wcnt_i};
    end
    rd_q <= mem[raddr_i];
  end

  assign rfree_o = rd_q[27:11];
  assign rcnt_o  = rd_q[10:0];
endmodule

### rtl/core/page_first_fit_record_store_top.sv
// Top level of the paged first-fit record store.
// Depends on pffrs_pkg and pffrs_page_table.
`timescale 1ns / 1ps
// One item at a time. The page table is read page by page, each page through
// a read state and a check state; a search reads the key memory one slot per
// cycle after each page header. A status item gives one result per page in
// use (a single result when no page is in use), each waiting for a free output
// register. The next item is taken once the result register has been loaded
// and a result held there does not block input acceptance.
module page_first_fit_record_store_top #(
  parameter int unsigned MAX_PAGES = 16,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pffrs_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pffrs_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import pffrs_pkg::*;

  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam int unsigned RW = $clog2(MAX_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRD   = 4'd1;
  localparam logic [3:0] S_PCHK  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_SHDR  = 4'd6;
  localparam logic [3:0] S_SHCHK = 4'd7;

  logic [3:0]    state_q, state_d;
  logic [15:0]   page_size_q;
  in_item_t      item_q;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] pg_q, pg_d;
  logic [RW-1:0] sl_q, sl_d;
  logic [RW-1:0] pcnt_q, pcnt_d;
  logic          ov_q;
  out_item_t     res_q, res_d;
  out_item_t     out_q;
  logic          res_load;

  // Page table port signals.
  logic          pt_we;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [16:0]   pt_wfree, pt_rfree;
  logic [10:0]   pt_wcnt, pt_rcnt;

  pffrs_page_table #(.AW(PW)) u_pt (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wfree_i(pt_wfree),
    .wcnt_i(pt_wcnt), .raddr_i(pt_raddr), .rfree_o(pt_rfree), .rcnt_o(pt_rcnt)
  );

  // Key memory, one word per slot.
  logic [31:0]         keys [2**(PW+SW)];
  logic                key_we;
  logic [PW+SW-1:0]    key_waddr, key_raddr;
  logic [31:0]         key_rd_q;
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys[key_waddr] <= item_q.value;
    end
    key_rd_q <= keys[key_raddr];
  end

  logic [16:0] need, empty_cap;
  assign need      = {1'b0, item_q.record_size} + SlotOverhead;
  assign empty_cap = ({1'b0, page_size_q} >= HeaderBytes) ?
                     ({1'b0, page_size_q} - HeaderBytes) : 17'd0;

  logic out_free;
  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    pg_d     = pg_q;
    sl_d     = sl_q;
    pcnt_d   = pcnt_q;
    res_d    = res_q;
    res_load = 1'b0;
    pt_we    = 1'b0;
    pt_waddr = pg_q[PW-1:0];
    pt_wfree = 17'd0;
    pt_wcnt  = 11'd0;
    pt_raddr = pg_q[PW-1:0];
    key_we   = 1'b0;
    key_waddr = {pg_q[PW-1:0], pcnt_q[SW-1:0]};
    key_raddr = {pg_q[PW-1:0], sl_q[SW-1:0]};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pg_d = '0;
          sl_d = '0;
          unique case (in_item_i.kind)
            KIND_INSERT: state_d = S_PRD;
            KIND_SEARCH: state_d = S_SHDR;
            KIND_STATUS: state_d = S_PRD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_PRD: begin
        // Page read issued; page count checks happen here too.
        res_d = '0;
        res_d.page_count = 5'(used_q);
        res_d.last = 1'b1;
        if (item_q.kind == KIND_INSERT && need > empty_cap) begin
          res_d.status = ST_TOO_LARGE;
          state_d = S_EMIT;
        end else if (pg_q >= used_q) begin
          if (item_q.kind == KIND_STATUS) begin
            state_d = S_EMIT;
          end else if (used_q >= CW'(MAX_PAGES)) begin
            res_d.status = ST_FULL;
            state_d = S_EMIT;
          end else begin
            // Open a new page and place the record in slot zero.
            pt_we    = 1'b1;
            pt_wfree = empty_cap - need;
            pt_wcnt  = 11'd1;
            key_we   = 1'b1;
            key_waddr = {pg_q[PW-1:0], {SW{1'b0}}};
            used_d   = used_q + 1'b1;
            res_d.page_index = 4'(pg_q);
            res_d.page_count = 5'(used_q + 1'b1);
            state_d  = S_EMIT;
          end
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        pcnt_d = RW'(pt_rcnt);
        if (item_q.kind == KIND_STATUS) begin
          if (out_free) begin
            res_d = '0;
            res_d.page_index = 4'(pg_q);
            res_d.page_count = 5'(used_q);
            res_d.record_count = 7'(pt_rcnt);
            res_d.last = (pg_q + 1'b1 == used_q);
            res_load = 1'b1;
            pg_d = pg_q + 1'b1;
            state_d = res_d.last ? S_IDLE : S_PRD;
          end
        end else if (pt_rfree >= need && pt_rcnt < 11'(MAX_SLOTS)) begin
          pt_we    = 1'b1;
          pt_wfree = pt_rfree - need;
          pt_wcnt  = pt_rcnt + 11'd1;
          key_we   = 1'b1;
          key_waddr = {pg_q[PW-1:0], pt_rcnt[SW-1:0]};
          res_d = '0;
          res_d.page_index = 4'(pg_q);
          res_d.slot_index = 6'(pt_rcnt);
          res_d.page_count = 5'(used_q);
          res_d.last = 1'b1;
          state_d = S_EMIT;
        end else begin
          pg_d = pg_q + 1'b1;
          state_d = S_PRD;
        end
      end
      S_SHDR: begin
        res_d = '0;
        res_d.page_count = 5'(used_q);
        res_d.last = 1'b1;
        if (pg_q >= used_q) begin
          res_d.status = ST_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          state_d = S_SHCHK;
        end
      end
      S_SHCHK: begin
        pcnt_d = RW'(pt_rcnt);
        sl_d = '0;
        if (pt_rcnt == 11'd0) begin
          pg_d = pg_q + 1'b1;
          state_d = S_SHDR;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        // Key read of slot sl_q is in flight.
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (key_rd_q == item_q.value) begin
          res_d.page_index = 4'(pg_q);
          res_d.slot_index = 6'(sl_q);
          state_d = S_EMIT;
        end else if (sl_q + 1'b1 >= pcnt_q) begin
          pg_d = pg_q + 1'b1;
          state_d = S_SHDR;
        end else begin
          sl_d = sl_q + 1'b1;
          key_raddr = {pg_q[PW-1:0], sl_d[SW-1:0]};
          state_d = S_SCHK;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      ov_q        <= 1'b0;
      page_size_q <= PageSizeRst;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        page_size_q <= cfg_wdata_i;
      end
      if (res_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers; the output register changes only when a result is loaded.
  always_ff @(posedge clk_i) begin
    pg_q   <= pg_d;
    sl_q   <= sl_d;
    pcnt_q <= pcnt_d;
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    res_q <= res_d;
    if (res_load) begin
      out_q <= res_d;
    end
  end
endmodule

### rtl/core/pffrs_checker.sv
// Port-level assertion checker for the paged first-fit record store.
// Depends on pffrs_pkg; bound to the top level at the end of the file.
`timescale 1ns / 1ps
module pffrs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pffrs_pkg::out_item_t out_item_o
);
  import pffrs_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Page count never exceeds sixteen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.page_count <= 5'd16)
    else $error("page count out of range");

  // Error results point at page zero, slot zero, and are marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.page_index == 4'd0 && out_item_o.slot_index == 6'd0 &&
      out_item_o.last)
    else $error("error result carries a location");

  // Store full only when every page is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |-> out_item_o.page_count == 5'd16)
    else $error("full reported with free pages");
endmodule

bind page_first_fit_record_store_top pffrs_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_item_o
);
